FILE: design/snmd_pkg.sv
package snmd_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int TIME_BITS_DEF  = 32;
  localparam int FRAC_BITS      = 16;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 8;
  localparam int DIST_W         = 24;

  localparam logic [CFG_IDX_W-1:0] REG_WHIZ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COOL = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HEAD = CFG_IDX_W'(3);

  localparam logic [CFG_W-1:0] WHIZ_RST = CFG_W'(200);
  localparam logic [CFG_W-1:0] HIT_RST  = CFG_W'(50);
  localparam logic [CFG_W-1:0] COOL_RST = CFG_W'(300);
  localparam logic [CFG_W-1:0] HEAD_RST = CFG_W'(80);

  typedef struct packed {
    logic                 done;
    logic [FRAC_BITS-1:0] quot;
  } div_sts_t;

endpackage

FILE: design/snmd_div.sv
module snmd_div
  import snmd_pkg::*;
#(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output div_sts_t     sts
);

  localparam int CW = $clog2(FRAC_BITS);

  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic [W-1:0]   rem_r;
  logic [W-1:0]   den_r;
  logic [FRAC_BITS-1:0] q_r;
  logic           done_r;
  logic [W:0]     sh;
  logic           ge;
  logic [W:0]     diff;

  // one quotient bit per cycle; remainder stays below the divisor
  assign sh   = {rem_r, 1'b0};
  assign ge   = sh >= {1'b0, den_r};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? diff[W-1:0] : sh[W-1:0];
        q_r   <= {q_r[FRAC_BITS-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.done = done_r;
  assign sts.quot = q_r;

endmodule

FILE: design/snmd_sqrt.sv
module snmd_sqrt #(
  parameter int W = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [W-1:0]     rad,
  output logic             done,
  output logic [W/2-1:0]   root,
  output logic             exact
);

  localparam int SQW = W / 2;
  localparam int RW  = SQW + 3;
  localparam int CW  = $clog2(SQW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rad_r;
  logic [RW-1:0] rem_r;
  logic [SQW-1:0] root_r;
  logic [RW-1:0] rem2;
  logic [RW-1:0] trial;
  logic          ge;

  // bring down two radicand bits per cycle, one root bit out
  assign rem2  = {rem_r[RW-3:0], rad_r[W-1:W-2]};
  assign trial = RW'({root_r, 2'b01});
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[W-3:0], 2'b00};
        rem_r  <= ge ? rem2 - trial : rem2;
        root_r <= {root_r[SQW-2:0], ge};
        cnt_r  <= cnt_r + CW'(1);
        if (cnt_r == CW'(SQW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign root  = root_r;
  // radicand was a perfect square: nothing left over
  assign exact = rem_r == '0;

endmodule

FILE: design/segment_near_miss_detector.sv
// Near-miss detector for a projectile segment passing a listener.
// Input channel (in_valid/in_ready): segment start/end, listener position,
// alive flag and time stamp. Output channel (out_valid/out_ready): one result
// per input transaction: triggered, intensity, closest point, distance.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while no transaction is in flight.
// One item at a time through a bit-serial multiply-accumulate (twelve
// products), a shared 16-step divider and a bit-serial square root. The
// divider runs for the projection only when it is not clamped, and for the
// intensity only when the item fires.
// in_ready is high only when the block is idle. A finished result sits in
// the output register while the next item is taken; if the receiver stalls,
// the following result waits in its last state until the register frees.
// Reset (rst_n, synchronous) restores the register defaults, clears the
// cooldown history and drops out_valid.
module segment_near_miss_detector
  import snmd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_start_z,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_end_z,
  input  logic signed [COORD_BITS-1:0] in_listener_x,
  input  logic signed [COORD_BITS-1:0] in_listener_y,
  input  logic signed [COORD_BITS-1:0] in_listener_z,
  input  logic                         in_listener_alive,
  input  logic [31:0]                  in_now_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_triggered,
  output logic [15:0]                  out_intensity,
  output logic signed [COORD_BITS-1:0] out_closest_x,
  output logic signed [COORD_BITS-1:0] out_closest_y,
  output logic signed [COORD_BITS-1:0] out_closest_z,
  output logic [DIST_W-1:0]            out_distance,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data
);

  localparam int C    = COORD_BITS;
  localparam int MW   = (C > 17) ? C : 17;
  localparam int XW   = MW + 2;
  localparam int PW   = 2 * XW + 2;
  localparam int SQW  = PW / 2;
  localparam int CNTW = $clog2(XW);
  localparam int DXW  = SQW + DIST_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_NEXT = 3'd3;
  localparam logic [2:0] ST_DIVT = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_DIVI = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic [1:0] GRP_LEN  = 2'd0;
  localparam logic [1:0] GRP_DOT  = 2'd1;
  localparam logic [1:0] GRP_PNT  = 2'd2;
  localparam logic [1:0] GRP_DIST = 2'd3;

  localparam logic signed [PW-1:0] RND_HALF = PW'(1 << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS:0]   T_ONE    = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [DIST_W-1:0]    DIST_MAX = '1;

  logic [2:0]            state_r;
  logic [1:0]            grp_r;
  logic [1:0]            ax_r;
  logic [CNTW-1:0]       cnt_r;

  logic [CFG_W-1:0]      whiz_r, hit_r, cool_r, head_r;
  logic [TIME_BITS-1:0]  last_fire_r;
  logic                  has_fired_r;

  logic signed [C-1:0]   s_r [3];
  logic signed [C-1:0]   e_r [3];
  logic signed [C-1:0]   l_r [3];
  logic                  alive_r;
  logic [TIME_BITS-1:0]  now_r;

  logic signed [PW-1:0]  acc_r;
  logic signed [PW-1:0]  mcand_r;
  logic [XW-1:0]         mpl_r;
  logic signed [PW-1:0]  lensq_r;
  logic [FRAC_BITS:0]    t_r;
  logic signed [XW-1:0]  c_r [3];
  logic [SQW-1:0]        d_r;
  logic [15:0]           inten_r;
  logic                  fire_r;

  logic                  div_start_r;
  logic [PW-1:0]         div_num_r;
  logic [PW-1:0]         div_den_r;
  div_sts_t              div_sts;
  logic                  sqrt_start_r;
  logic                  sqrt_done;
  logic [SQW-1:0]        sqrt_root;
  logic                  sqrt_exact;

  logic                  out_valid_r;
  logic                  out_trig_r;
  logic [15:0]           out_inten_r;
  logic signed [C-1:0]   out_cx_r, out_cy_r, out_cz_r;
  logic [DIST_W-1:0]     out_dist_r;

  logic signed [XW-1:0]  ab [3];
  logic signed [XW-1:0]  p  [3];
  logic signed [XW-1:0]  ap [3];
  logic signed [XW-1:0]  dm [3];
  logic signed [XW-1:0]  op_a;
  logic [XW-1:0]         op_b;
  logic signed [PW-1:0]  rnd;
  logic signed [XW-1:0]  c_new;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  fire;
  logic [DXW-1:0]        dext;
  logic                  mul_last;
  logic                  dot_pos;
  logic                  t_div_go;
  logic                  i_div_go;
  logic                  div_go;
  logic                  sqrt_go;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab[i] = XW'(e_r[i]) - XW'(s_r[i]);
      p[i]  = XW'(l_r[i]);
      ap[i] = '0;
      dm[i] = '0;
    end
    p[2] = XW'(l_r[2]) + XW'($signed({1'b0, head_r}));
    for (int i = 0; i < 3; i++) begin
      ap[i] = p[i] - XW'(s_r[i]);
      dm[i] = p[i] - c_r[i];
    end
  end

  always_comb begin
    case (grp_r)
      GRP_LEN: begin
        op_a = ab[ax_r];
        op_b = ab[ax_r];
      end
      GRP_DOT: begin
        op_a = ap[ax_r];
        op_b = ab[ax_r];
      end
      GRP_PNT: begin
        op_a = ab[ax_r];
        op_b = XW'(t_r);
      end
      default: begin
        op_a = dm[ax_r];
        op_b = dm[ax_r];
      end
    endcase
  end

  assign mul_last = cnt_r == CNTW'(XW - 1);
  assign rnd      = (acc_r + RND_HALF) >>> FRAC_BITS;
  assign c_new    = XW'(s_r[ax_r]) + XW'(rnd);
  assign elapsed  = now_r - last_fire_r;
  // upper bound is on the squared distance: at d == whiz it must be a perfect square
  assign fire     = alive_r && (lensq_r != '0)
                  && ((d_r < SQW'(whiz_r)) || ((d_r == SQW'(whiz_r)) && sqrt_exact))
                  && (d_r >= SQW'(hit_r))
                  && (!has_fired_r || elapsed >= TIME_BITS'(cool_r));
  assign dext     = DXW'(d_r);

  // dot sum is in acc_r at the end of the dot group
  assign dot_pos  = (lensq_r != '0) && !acc_r[PW-1] && (acc_r != '0);
  assign t_div_go = (state_r == ST_NEXT) && (grp_r == GRP_DOT) && (ax_r == 2'd2)
                  && dot_pos && (acc_r < lensq_r);
  assign i_div_go = (state_r == ST_DIVI) && !fire_r && !div_start_r && fire
                  && (whiz_r != '0) && (d_r != '0);
  assign div_go   = t_div_go || i_div_go;
  assign sqrt_go  = (state_r == ST_NEXT) && (grp_r == GRP_DIST) && (ax_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whiz_r <= WHIZ_RST;
      hit_r  <= HIT_RST;
      cool_r <= COOL_RST;
      head_r <= HEAD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WHIZ: whiz_r <= cfg_data;
        REG_HIT:  hit_r  <= cfg_data;
        REG_COOL: cool_r <= cfg_data;
        REG_HEAD: head_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      grp_r        <= GRP_LEN;
      ax_r         <= '0;
      cnt_r        <= '0;
      has_fired_r  <= 1'b0;
      last_fire_r  <= '0;
      div_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      div_start_r  <= div_go;
      sqrt_start_r <= sqrt_go;
      if (out_valid_r && out_ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            s_r[0]  <= in_start_x;
            s_r[1]  <= in_start_y;
            s_r[2]  <= in_start_z;
            e_r[0]  <= in_end_x;
            e_r[1]  <= in_end_y;
            e_r[2]  <= in_end_z;
            l_r[0]  <= in_listener_x;
            l_r[1]  <= in_listener_y;
            l_r[2]  <= in_listener_z;
            alive_r <= in_listener_alive;
            now_r   <= TIME_BITS'(in_now_ms);
            grp_r   <= GRP_LEN;
            ax_r    <= '0;
            acc_r   <= '0;
            t_r     <= '0;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          mcand_r <= PW'(op_a);
          mpl_r   <= op_b;
          cnt_r   <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          // top multiplier bit carries negative weight
          if (mpl_r[0]) begin
            acc_r <= mul_last ? acc_r - mcand_r : acc_r + mcand_r;
          end
          mcand_r <= mcand_r <<< 1;
          mpl_r   <= mpl_r >> 1;
          cnt_r   <= cnt_r + CNTW'(1);
          if (mul_last) begin
            state_r <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (ax_r != 2'd2) begin
            ax_r <= ax_r + 2'd1;
          end else begin
            ax_r <= '0;
          end
          case (grp_r)
            GRP_LEN: begin
              state_r <= ST_LOAD;
              if (ax_r == 2'd2) begin
                lensq_r <= acc_r;
                acc_r   <= '0;
                grp_r   <= GRP_DOT;
              end
            end
            GRP_DOT: begin
              if (ax_r == 2'd2) begin
                acc_r <= '0;
                grp_r <= GRP_PNT;
                if (!dot_pos) begin
                  t_r     <= '0;
                  state_r <= ST_LOAD;
                end else if (acc_r >= lensq_r) begin
                  t_r     <= T_ONE;
                  state_r <= ST_LOAD;
                end else begin
                  div_num_r <= acc_r;
                  div_den_r <= lensq_r;
                  state_r   <= ST_DIVT;
                end
              end else begin
                state_r <= ST_LOAD;
              end
            end
            GRP_PNT: begin
              c_r[ax_r] <= c_new;
              acc_r     <= '0;
              state_r   <= ST_LOAD;
              if (ax_r == 2'd2) begin
                grp_r <= GRP_DIST;
              end
            end
            default: begin
              if (ax_r == 2'd2) begin
                state_r <= ST_SQRT;
              end else begin
                state_r <= ST_LOAD;
              end
            end
          endcase
        end
        ST_DIVT: begin
          if (div_sts.done) begin
            t_r     <= {1'b0, div_sts.quot};
            state_r <= ST_LOAD;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            d_r     <= sqrt_root;
            state_r <= ST_DIVI;
            fire_r  <= 1'b0;
            inten_r <= '0;
          end
        end
        ST_DIVI: begin
          // first cycle decides; then wait on the divider if it was launched
          if (!fire_r && !div_start_r) begin
            fire_r <= fire;
            if (fire) begin
              last_fire_r <= now_r;
              has_fired_r <= 1'b1;
              if (whiz_r == '0) begin
                state_r <= ST_OUT;
              end else if (d_r == '0) begin
                inten_r <= '1;
                state_r <= ST_OUT;
              end else begin
                div_num_r <= PW'(whiz_r - CFG_W'(d_r));
                div_den_r <= PW'(whiz_r);
              end
            end else begin
              state_r <= ST_OUT;
            end
          end else if (div_sts.done) begin
            inten_r <= div_sts.quot;
            state_r <= ST_OUT;
          end
        end
        default: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_trig_r  <= fire_r;
            out_inten_r <= inten_r;
            out_cx_r    <= c_r[0][C-1:0];
            out_cy_r    <= c_r[1][C-1:0];
            out_cz_r    <= c_r[2][C-1:0];
            out_dist_r  <= (dext > DXW'(DIST_MAX)) ? DIST_MAX : dext[DIST_W-1:0];
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  snmd_div #(
    .W (PW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .sts   (div_sts)
  );

  snmd_sqrt #(
    .W (PW)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start_r),
    .rad   (acc_r),
    .done  (sqrt_done),
    .root  (sqrt_root),
    .exact (sqrt_exact)
  );

  assign in_ready      = state_r == ST_IDLE;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_triggered = out_trig_r;
  assign out_intensity = out_inten_r;
  assign out_closest_x = out_cx_r;
  assign out_closest_y = out_cy_r;
  assign out_closest_z = out_cz_r;
  assign out_distance  = out_dist_r;

endmodule

FILE: tb/testbench.sv
module testbench;
  import snmd_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int LIMIT = 3000000;
  localparam int SETTLE = 500;

  typedef struct {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez, lx, ly, lz;
    logic                 alive;
    logic [31:0]          now;
  } seg_item_t;

  typedef struct {
    logic                 trig;
    logic [15:0]          inten;
    logic signed [CW-1:0] cx, cy, cz;
    logic [DIST_W-1:0]    dist_val;
  } miss_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  seg_item_t cur;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_triggered;
  logic [15:0] out_intensity;
  logic signed [CW-1:0] out_closest_x, out_closest_y, out_closest_z;
  logic [DIST_W-1:0] out_distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  seg_item_t pending_items[$];
  miss_result_t expected_results[$];

  // mirror of the block's registers and cooldown history
  logic [15:0] m_whiz, m_hit, m_cool, m_head;
  logic [31:0] m_last_fire;
  logic        m_fired;

  int accepted_cnt = 0, sent_cnt = 0, gap_left = 0, burst_left = 1;
  int err_cnt = 0, cycles = 0, ready_pct = 100;
  logic [31:0] now_clk = 0;

  segment_near_miss_detector DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_start_x(cur.sx), .in_start_y(cur.sy), .in_start_z(cur.sz),
    .in_end_x(cur.ex), .in_end_y(cur.ey), .in_end_z(cur.ez),
    .in_listener_x(cur.lx), .in_listener_y(cur.ly), .in_listener_z(cur.lz),
    .in_listener_alive(cur.alive), .in_now_ms(cur.now),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_triggered(out_triggered), .out_intensity(out_intensity),
    .out_closest_x(out_closest_x), .out_closest_y(out_closest_y),
    .out_closest_z(out_closest_z), .out_distance(out_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint floor_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic miss_result_t predict_near_miss(seg_item_t it);
    longint s[3], ab[3], p[3], c[3], ap;
    longint lensq, dot, dist2, t, d;
    logic [127:0] num, cand;
    logic [31:0] elapsed;
    logic fire;
    miss_result_t r;
    s[0] = longint'(it.sx); s[1] = longint'(it.sy); s[2] = longint'(it.sz);
    ab[0] = longint'(it.ex) - s[0];
    ab[1] = longint'(it.ey) - s[1];
    ab[2] = longint'(it.ez) - s[2];
    p[0] = longint'(it.lx); p[1] = longint'(it.ly);
    p[2] = longint'(it.lz) + longint'(m_head);
    lensq = 0; dot = 0; dist2 = 0; t = 0; d = 0;
    for (int i = 0; i < 3; i++) begin
      ap = p[i] - s[i];
      dot += ap * ab[i];
      lensq += ab[i] * ab[i];
    end
    if (lensq != 0 && dot > 0) begin
      if (dot >= lensq) t = 65536;
      else begin
        num = 128'(dot) << 16;
        t = longint'(num / 128'(lensq));
      end
    end
    for (int i = 0; i < 3; i++) begin
      c[i] = s[i] + floor_q16(ab[i] * t);
      dist2 += (p[i] - c[i]) * (p[i] - c[i]);
    end
    for (int b = 40; b >= 0; b--) begin
      cand = 128'(d) | (128'd1 << b);
      if (cand * cand <= 128'(dist2)) d = longint'(cand);
    end
    elapsed = it.now - m_last_fire;
    fire = it.alive && lensq != 0 &&
           dist2 <= longint'(m_whiz) * longint'(m_whiz) &&
           dist2 >= longint'(m_hit) * longint'(m_hit) &&
           (!m_fired || elapsed >= 32'(m_cool));
    r.inten = '0;
    if (fire) begin
      m_last_fire = it.now;
      m_fired = 1'b1;
      if (m_whiz != 0 && d <= longint'(m_whiz)) begin
        t = ((longint'(m_whiz) - d) << 16) / longint'(m_whiz);
        r.inten = t > 65535 ? 16'hFFFF : 16'(t);
      end
    end
    r.trig = fire;
    r.cx = CW'(c[0]); r.cy = CW'(c[1]); r.cz = CW'(c[2]);
    r.dist_val = d > 64'hFFFFFF ? 24'hFFFFFF : 24'(d);
    return r;
  endfunction

  // accept side: mirror config writes, predict on input transactions, check on output transactions
  always @(posedge clk) begin
    miss_result_t exp_r;
    cycles <= cycles + 1;
    if (!rst_n) begin
      m_whiz = WHIZ_RST; m_hit = HIT_RST; m_cool = COOL_RST; m_head = HEAD_RST;
      m_last_fire = '0; m_fired = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WHIZ: m_whiz = cfg_data;
          REG_HIT:  m_hit  = cfg_data;
          REG_COOL: m_cool = cfg_data;
          REG_HEAD: m_head = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_near_miss(cur));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result transaction");
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.trig !== out_triggered || exp_r.inten !== out_intensity ||
              exp_r.cx !== out_closest_x || exp_r.cy !== out_closest_y ||
              exp_r.cz !== out_closest_z || exp_r.dist_val !== out_distance) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: exp trig=%0d int=%0d c=(%0d,%0d,%0d) d=%0d",
                       exp_r.trig, exp_r.inten, exp_r.cx, exp_r.cy, exp_r.cz,
                       exp_r.dist_val,
                       " got trig=%0d int=%0d c=(%0d,%0d,%0d) d=%0d",
                       out_triggered, out_intensity, out_closest_x,
                       out_closest_y, out_closest_z, out_distance);
          end
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // sender: bursts with random gaps; hold the transaction until accepted
  always @(negedge clk) begin
    if (rst_n && (!in_valid || accepted_cnt == sent_cnt)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur <= pending_items.pop_front();
        in_valid <= 1'b1;
        sent_cnt <= sent_cnt + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
        end else burst_left <= burst_left - 1;
      end else in_valid <= 1'b0;
    end
  end

  // receiver: random stalls, with a stall density that is redrawn periodically
  always @(negedge clk) begin
    if (cycles % 300 == 0) ready_pct <= ($urandom_range(0, 2) == 0) ? 100 :
                                          $urandom_range(5, 90);
    out_ready <= ($urandom_range(0, 99) < ready_pct);
  end

  function automatic logic signed [CW-1:0] clip(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return CW'(v);
  endfunction

  function automatic seg_item_t near_item(int spread);
    seg_item_t it;
    longint bx, by, bz, vx, vy, vz;
    bx = $signed($urandom_range(0, 8000000)) - 4000000;
    by = $signed($urandom_range(0, 8000000)) - 4000000;
    bz = $signed($urandom_range(0, 8000000)) - 4000000;
    it.lx = clip(bx + $signed($urandom_range(0, 2 * spread)) - spread);
    it.ly = clip(by + $signed($urandom_range(0, 2 * spread)) - spread);
    it.lz = clip(bz + $signed($urandom_range(0, 2 * spread)) - spread);
    vx = $signed($urandom_range(0, 6000)) - 3000;
    vy = $signed($urandom_range(0, 6000)) - 3000;
    vz = $signed($urandom_range(0, 6000)) - 3000;
    if ($urandom_range(0, 1)) begin
      it.sx = clip(bx - vx); it.sy = clip(by - vy); it.sz = clip(bz - vz);
      it.ex = clip(bx + vx); it.ey = clip(by + vy); it.ez = clip(bz + vz);
    end else begin
      it.sx = clip(bx + vx); it.sy = clip(by + vy); it.sz = clip(bz + vz);
      it.ex = clip(bx + $signed($urandom_range(0, 6000)) - 3000);
      it.ey = clip(by + $signed($urandom_range(0, 6000)) - 3000);
      it.ez = clip(bz + $signed($urandom_range(0, 6000)) - 3000);
    end
    it.alive = ($urandom_range(0, 9) != 0);
    now_clk += $urandom_range(0, 500);
    it.now = now_clk;
    return it;
  endfunction

  function automatic seg_item_t wild_item();
    seg_item_t it;
    it.sx = CW'($urandom); it.sy = CW'($urandom); it.sz = CW'($urandom);
    it.ex = CW'($urandom); it.ey = CW'($urandom); it.ez = CW'($urandom);
    it.lx = CW'($urandom); it.ly = CW'($urandom); it.lz = CW'($urandom);
    it.alive = 1'($urandom_range(0, 1));
    it.now = $urandom;
    return it;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_random(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: pending_items.push_back(wild_item());
        2: pending_items.push_back(near_item(50));
        default: pending_items.push_back(near_item(400));
      endcase
    end
  endtask

  initial begin
    seg_item_t it;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: first firing, cooldown, degenerate, dead listener, clamps, extremes
    it = '{sx: -100, sy: 0, sz: 0, ex: 100, ey: 0, ez: 0, lx: 0, ly: 0, lz: 20,
           alive: 1, now: 5};
    pending_items.push_back(it);          // first firing ignores cooldown
    it.now = 100; pending_items.push_back(it);   // within cooldown
    it.now = 305; pending_items.push_back(it);   // exactly cooldown
    it.now = 32'hFFFF_FF00; pending_items.push_back(it);
    it.now = 32'h0000_0040; pending_items.push_back(it);  // time wraps
    it.now = 32'h0000_0010; pending_items.push_back(it);  // time goes backward
    it.alive = 0; it.now = 5000; pending_items.push_back(it);
    it.alive = 1; it.ex = -100; it.now = 9000; pending_items.push_back(it); // degenerate
    it = '{sx: 0, sy: 0, sz: 0, ex: 1000, ey: 0, ez: 0, lx: -150, ly: 0, lz: -80,
           alive: 1, now: 20000};
    pending_items.push_back(it);          // T clamped to zero
    it.lx = 1150; it.now = 30000; pending_items.push_back(it);  // T clamped to one
    it.lx = 500; it.lz = -80; it.now = 40000; pending_items.push_back(it); // distance 0
    it.lz = -30; it.now = 50000; pending_items.push_back(it);   // exactly hit radius
    it.lz = 120; it.now = 60000; pending_items.push_back(it);   // exactly whiz radius
    it.lz = 121; it.now = 70000; pending_items.push_back(it);
    it = '{sx: -24'sd8388608, sy: -24'sd8388608, sz: -24'sd8388608,
           ex: 24'sd8388607, ey: 24'sd8388607, ez: 24'sd8388607,
           lx: 24'sd8388607, ly: -24'sd8388608, lz: 24'sd8388607,
           alive: 1, now: 32'hFFFF_FFFF};
    pending_items.push_back(it);
    it.sx = 24'sd8388607; it.ex = -24'sd8388608; it.lx = -24'sd8388608;
    it.lz = -24'sd8388608; it.now = 0; pending_items.push_back(it);
    it = '{sx: 24'sd8388607, sy: 24'sd8388607, sz: 24'sd8388607,
           ex: 24'sd8388607, ey: 24'sd8388607, ez: 24'sd8388607,
           lx: -24'sd8388608, ly: -24'sd8388608, lz: -24'sd8388608,
           alive: 1, now: 1};
    pending_items.push_back(it);          // degenerate, distance saturates
    it.ex = 24'sd8388606; pending_items.push_back(it);
    add_random(150);
    wait_drained();

    write_reg(REG_WHIZ, 16'hFFFF); write_reg(REG_HIT, 16'd0);
    write_reg(REG_COOL, 16'd0); write_reg(REG_HEAD, 16'hFFFF);
    add_random(150);
    wait_drained();

    write_reg(REG_WHIZ, 16'd1); write_reg(REG_HIT, 16'd0);
    write_reg(REG_HEAD, 16'd0); write_reg(REG_COOL, 16'hFFFF);
    write_reg(8'd7, 16'h1234);            // unknown index, ignored
    add_random(120);
    wait_drained();

    write_reg(REG_WHIZ, 16'd300); write_reg(REG_HIT, 16'd500);  // never fires
    write_reg(REG_COOL, 16'd50); write_reg(REG_HEAD, 16'd40);
    add_random(100);
    wait_drained();

    write_reg(REG_WHIZ, 16'd0); write_reg(REG_HIT, 16'd0);
    write_reg(REG_HEAD, 16'd0);
    add_random(60);
    wait_drained();

    write_reg(REG_WHIZ, 16'd2000); write_reg(REG_HIT, 16'd10);
    write_reg(REG_COOL, 16'd200); write_reg(REG_HEAD, 16'd100);
    add_random(350);
    wait_drained();

    if (err_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/snmd_pkg.sv
design/snmd_div.sv
design/snmd_sqrt.sv
design/segment_near_miss_detector.sv
tb/testbench.sv
